// ===== design/bsr_pkg.sv =====
`timescale 1ns / 1ps
package bsr_pkg;

	localparam int FRAC_BITS = 32;
	localparam int RAD_W     = 32;
	localparam int ROOT_W    = 64;
	localparam int HALF_W    = 32;
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int PASS_W    = 10;
	localparam int TOL_W     = 32;
	localparam int STEP_W    = 3;
	localparam int DATA_OUT_W = ((ROOT_W + PASS_W + 7) / 8) * 8;

	localparam logic [ROOT_W-1:0] ONE_FIXED = ROOT_W'(1) << FRAC_BITS;

	localparam logic REG_TOLERANCE  = 1'b0;
	localparam logic REG_ITER_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		MSEL_LL = 2'd0,
		MSEL_LH = 2'd1,
		MSEL_HH = 2'd2
	} msel_t;

	typedef enum logic [1:0] {
		ACC_NONE    = 2'd0,
		ACC_LOAD    = 2'd1,
		ACC_ADD_MID = 2'd2,
		ACC_ADD_HI  = 2'd3
	} acc_op_t;

	typedef enum logic {
		BR_NEXT = 1'b0,
		BR_TEST = 1'b1
	} branch_t;

	typedef struct packed {
		msel_t             msel;
		acc_op_t           acc;
		logic              upd;
		logic              settle;
		branch_t           br;
		logic [STEP_W-1:0] nxt;
	} ucode_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} cmp_t;

	localparam logic [STEP_W-1:0] STEP_MUL_LL = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_MUL_LH = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_MUL_HH = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_UPDATE = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_SETTLE = STEP_W'(4);

	localparam ucode_t UCODE_NOP = '{msel: MSEL_LL, acc: ACC_NONE, upd: 1'b0,
		settle: 1'b0, br: BR_NEXT, nxt: STEP_SETTLE};

	function automatic ucode_t ucode_rom(logic [STEP_W-1:0] addr);
		ucode_t w;
		w = UCODE_NOP;
		case (addr)
			STEP_MUL_LL: begin
				w.msel = MSEL_LL;
				w.acc  = ACC_LOAD;
				w.nxt  = STEP_MUL_LH;
			end
			STEP_MUL_LH: begin
				w.msel = MSEL_LH;
				w.acc  = ACC_ADD_MID;
				w.nxt  = STEP_MUL_HH;
			end
			STEP_MUL_HH: begin
				w.msel = MSEL_HH;
				w.acc  = ACC_ADD_HI;
				w.nxt  = STEP_UPDATE;
			end
			STEP_UPDATE: begin
				w.upd = 1'b1;
				w.nxt = STEP_SETTLE;
			end
			STEP_SETTLE: begin
				w.settle = 1'b1;
				w.br     = BR_TEST;
				w.nxt    = STEP_MUL_LL;
			end
			default: w = UCODE_NOP;
		endcase
		return w;
	endfunction

endpackage

// ===== design/bisection_square_root.sv =====
`timescale 1ns / 1ps
// a negative radicand goes straight to the done state without a pass;
// otherwise each pass is five microcode steps
// around one 32x32 multiplier (three partial products, update, midpoint)
// throughput: one request at a time; the next is taken once the result is in the output register
// reset: arst_n clears control, tolerance returns to 1 and iteration_limit to 200
module bisection_square_root
	import bsr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_index,
	input  logic [TOL_W-1:0]      cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [RAD_W-1:0]      s_tdata,   // radicand
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_OUT_W-1:0] m_tdata,   // root, passes_used, zero fill
	output logic                  m_tuser    // negative_input
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [TOL_W-1:0]    tol_q;
	logic [PASS_W-1:0]   limit_q;
	logic [PASS_W-1:0]   limit_eff;
	logic [RAD_W-2:0]    n_q;
	logic [ROOT_W-1:0]   low_q;
	logic [ROOT_W-1:0]   high_q;
	logic [ROOT_W-1:0]   diff_q;
	logic [ROOT_W-1:0]   guess_q;
	logic [PASS_W-1:0]   passes_q;
	logic                neg_q;
	logic                m_valid_q;
	logic [ROOT_W-1:0]   m_root_q;
	logic [PASS_W-1:0]   m_passes_q;
	logic                m_neg_q;
	ucode_t              uw;
	ucode_t              mac_ctrl;
	cmp_t                cmp;
	logic [ROOT_W-1:0]   new_low;
	logic [ROOT_W-1:0]   new_high;
	logic [ROOT_W-1:0]   start_high;
	logic                go_on;
	logic                in_acc;
	logic                out_free;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;
	assign limit_eff = (limit_q == '0) ? PASS_W'(1) : limit_q;

	assign uw = ucode_rom(step_q);

	always_comb begin
		mac_ctrl = UCODE_NOP;
		if (state_q == ST_RUN) begin
			mac_ctrl = uw;
		end
	end

	bsr_mac u_mac (
		.clk   (clk),
		.ctrl  (mac_ctrl),
		.guess (guess_q),
		.n     (n_q),
		.cmp   (cmp)
	);

	always_comb begin
		new_low  = low_q;
		new_high = high_q;
		if (cmp.gt) begin
			new_high = guess_q;
		end else if (cmp.lt) begin
			new_low = guess_q;
		end
	end

	assign start_high = (ROOT_W'(s_tdata[RAD_W-2:0]) + ROOT_W'(1)) << FRAC_BITS;
	assign go_on      = (diff_q > ROOT_W'(tol_q)) && (passes_q < limit_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q   <= TOL_W'(1);
			limit_q <= PASS_W'(200);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOLERANCE:  tol_q   <= cfg_data;
				REG_ITER_LIMIT: limit_q <= cfg_data[PASS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= STEP_SETTLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						step_q  <= STEP_SETTLE;
						state_q <= s_tdata[RAD_W-1] ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (uw.br == BR_TEST && !go_on) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= uw.nxt;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// bracket and guess registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			n_q      <= s_tdata[RAD_W-2:0];
			neg_q    <= s_tdata[RAD_W-1];
			passes_q <= '0;
			low_q    <= '0;
			high_q   <= start_high;
			diff_q   <= start_high;
			guess_q  <= ONE_FIXED;
		end else if (state_q == ST_RUN) begin
			if (uw.upd) begin
				low_q    <= new_low;
				high_q   <= new_high;
				diff_q   <= new_high - new_low;
				passes_q <= passes_q + PASS_W'(1);
			end
			if (uw.settle) begin
				guess_q <= low_q + (diff_q >> 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_root_q   <= guess_q;
			m_passes_q <= passes_q;
			m_neg_q    <= neg_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = DATA_OUT_W'({m_passes_q, m_root_q});
	assign m_tuser  = m_neg_q;

endmodule

// ===== design/bsr_mac.sv =====
`timescale 1ns / 1ps
module bsr_mac
	import bsr_pkg::*;
(
	input  logic                   clk,
	input  ucode_t                 ctrl,
	input  logic [ROOT_W-1:0]      guess,
	input  logic [RAD_W-2:0]       n,
	output cmp_t                   cmp
);

	logic [HALF_W-1:0]   op_a;
	logic [HALF_W-1:0]   op_b;
	logic [2*HALF_W-1:0] prod;
	logic [SQ_W-1:0]     acc_q;
	logic [SQ_W-1:0]     target;

	always_comb begin
		case (ctrl.msel)
			MSEL_LL: begin
				op_a = guess[HALF_W-1:0];
				op_b = guess[HALF_W-1:0];
			end
			MSEL_LH: begin
				op_a = guess[HALF_W-1:0];
				op_b = guess[2*HALF_W-1:HALF_W];
			end
			MSEL_HH: begin
				op_a = guess[2*HALF_W-1:HALF_W];
				op_b = guess[2*HALF_W-1:HALF_W];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod = op_a * op_b;

	// cross term counted twice, hence one extra bit of shift
	always_ff @(posedge clk) begin
		case (ctrl.acc)
			ACC_LOAD:    acc_q <= SQ_W'(prod);
			ACC_ADD_MID: acc_q <= acc_q + (SQ_W'(prod) << (HALF_W + 1));
			ACC_ADD_HI:  acc_q <= acc_q + (SQ_W'(prod) << (2 * HALF_W));
			default:     acc_q <= acc_q;
		endcase
	end

	assign target = SQ_W'(n) << (2 * FRAC_BITS);
	assign cmp.gt = acc_q > target;
	assign cmp.lt = acc_q < target;

endmodule
